FILE: rtl/iiel_pkg.sv
// Shared types and constants for the indexed insert/erase list.
// Holds the command and result words, the operation and status codes,
// and the control word broadcast to the row of cells. No dependencies.
package iiel_pkg;

    // List depth and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // Command word
    typedef struct packed {
        t_op                       operation;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  value;
    } t_in_word;

    // Result word
    typedef struct packed {
        t_status                   status;
        logic signed [WORD_W-1:0]  entry_value;
        logic [COUNT_W-1:0]        entry_count;
    } t_out_word;

    // Control broadcast to every cell
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic [CMP_W-1:0]          pos;
        logic signed [WORD_W-1:0]  value;
    } t_shift_ctrl;

endpackage

FILE: rtl/iiel_cell.sv
// One cell of the list row: holds a single entry and shifts with its
// neighbors on insert and erase. Depends on iiel_pkg.
module iiel_cell (
    input  logic                               i_clk,
    input  iiel_pkg::t_shift_ctrl              i_ctrl,
    input  logic [iiel_pkg::IDX_W-1:0]         i_index,
    input  logic signed [iiel_pkg::WORD_W-1:0] i_left,
    input  logic signed [iiel_pkg::WORD_W-1:0] i_right,
    output logic signed [iiel_pkg::WORD_W-1:0] o_word
);
    import iiel_pkg::*;

    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;
    logic [CMP_W-1:0]         idx_x;

    assign idx_x = CMP_W'(i_index);

    // Insert: left above pos, value at pos; erase: right from pos up
    always_comb begin
        n_word = r_word;
        if (i_ctrl.ins) begin
            if (idx_x > i_ctrl.pos) begin
                n_word = i_left;
            end else if (idx_x == i_ctrl.pos) begin
                n_word = i_ctrl.value;
            end
        end else if (i_ctrl.del) begin
            if (idx_x >= i_ctrl.pos) begin
                n_word = i_right;
            end
        end
    end

    // Hold the entry (payload, no reset)
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

FILE: rtl/indexed_insert_erase_list.sv
// Top level of the indexed insert/erase list: command decode, count,
// read select and result register over a row of iiel_cell instances.
// Depends on iiel_pkg and iiel_cell.
//
//   channel   handshake                     payload
//   -------   ---------------------------   -----------------------------
//   command   start (taken when !busy)      i_cmd    (t_in_word)
//   result    o_result_valid (one cycle)    o_result (t_out_word)
//
// One command per cycle: the edge that takes a command registers its
// result word and raises o_result_valid. busy stays low, since every
// cell shifts alongside its neighbors on that same edge.
// Synchronous active-low reset clears the count and the result strobe;
// entries hold unknown data until an insert writes them.
// The result strobe lasts one cycle; the receiver cannot stall it.
module indexed_insert_erase_list (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  iiel_pkg::t_in_word    i_cmd,
    output logic                  o_result_valid,
    output iiel_pkg::t_out_word   o_result
);
    import iiel_pkg::*;

    logic signed [WORD_W-1:0] cell_word [CAPACITY];
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_valid;
    t_out_word                r_result;
    t_out_word                n_result;
    t_shift_ctrl              ctrl;
    logic                     accept;
    logic [CMP_W-1:0]         pos_x;
    logic [CMP_W-1:0]         cnt_x;
    logic signed [WORD_W-1:0] sel_word;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pos_x  = CMP_W'(i_cmd.position);
    assign cnt_x  = CMP_W'(r_count);

    // Select the entry at the command position
    always_comb begin
        sel_word = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (CMP_W'(k) == pos_x) begin
                sel_word = cell_word[k];
            end
        end
    end

    // Decode the command, check bounds, build the result word
    always_comb begin
        ctrl.ins   = 1'b0;
        ctrl.del   = 1'b0;
        ctrl.pos   = pos_x;
        ctrl.value = i_cmd.value;
        n_count    = r_count;
        n_result.status      = ST_OK;
        n_result.entry_value = '0;
        unique case (i_cmd.operation)
            OP_INSERT: begin
                if (cnt_x == CMP_W'(CAPACITY)) begin
                    n_result.status = ST_FULL;
                end else if (pos_x > cnt_x) begin
                    n_result.status = ST_RANGE;
                end else begin
                    ctrl.ins = accept;
                    n_count  = r_count + CNT_W'(1);
                end
            end
            OP_ERASE, OP_READ: begin
                if (r_count == '0) begin
                    n_result.status = ST_EMPTY;
                end else if (pos_x >= cnt_x) begin
                    n_result.status = ST_RANGE;
                end else begin
                    n_result.entry_value = sel_word;
                    if (i_cmd.operation == OP_ERASE) begin
                        ctrl.del = accept;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_result.status = ST_OK;
            end
        endcase
        n_result.entry_count = COUNT_W'(n_count);
    end

    // Row of cells fed by their neighbors; the ends take the command value and zero
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = i_cmd.value;
        end else begin : g_mid_l
            assign left_w = cell_word[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_word[g+1];
        end
        iiel_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_index (IDX_W'(g)),
            .i_left  (left_w),
            .i_right (right_w),
            .o_word  (cell_word[g])
        );
    end

    // Advance count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // Hold the result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_result;

endmodule
